### rtl/lgrk4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrk4_pkg
// Shared types and constants for the logistic growth RK4 integrator.
// ----------------------------------------------------------------------------
package lgrk4_pkg;

    // Widths of the item fields and of the fixed-point values
    localparam int STEP_COUNT_BITS = 16;
    localparam int FRAC_BITS       = 16;
    localparam int VAL_W           = 48;
    localparam int INIT_W          = 47;
    localparam int GROWTH_W        = 32;
    localparam int INVCAP_W        = 48;
    localparam int CFG_DATA_W      = 48;
    localparam int CFG_IDX_W       = 2;

    // Divide-by-six unit: bits retired per cycle and cycle count
    localparam int DIV_BITS  = 4;
    localparam int DIV_ITERS = 13;

    // Sequence counter in the controller
    localparam int CNT_W = 4;

    // RK4 stage codes
    localparam logic [1:0] STAGE_K1 = 2'd0;
    localparam logic [1:0] STAGE_K2 = 2'd1;
    localparam logic [1:0] STAGE_K3 = 2'd2;
    localparam logic [1:0] STAGE_K4 = 2'd3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL = 2'd0,
        CFG_GROWTH  = 2'd1,
        CFG_INVCAP  = 2'd2
    } cfg_idx_t;

    // Product selector for the shared multiplier
    typedef enum logic [1:0] {
        MOP_RATIO = 2'd0,   // r = q * inv_capacity
        MOP_TREND = 2'd1,   // t = q * growth_per_step
        MOP_SLOPE = 2'd2    // k = t * (1 - r)
    } mul_op_t;

    // Input transaction
    typedef struct packed {
        logic                       func;
        logic [STEP_COUNT_BITS-1:0] step_count;
    } req_item_t;

    // Result transaction
    typedef struct packed {
        logic signed [VAL_W-1:0] population;
        logic                    saturated;
    } rsp_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       in_load;
        logic       restart;
        logic       step_start;
        logic       mul_load;
        logic       mul_pp;
        logic [1:0] pp_sel;
        logic       mul_fin;
        mul_op_t    op;
        logic       acc;
        logic [1:0] stage;
        logic       div_load;
        logic       div_run;
        logic       y_update;
        logic       out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic steps_zero;
    } dp_sts_t;

endpackage

### rtl/lgrk4_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrk4_dp
// Datapath: configuration registers, population state, shared 32x32
// multiplier with partial-product accumulator, stage and sum logic, and a
// four-bit-per-cycle divide-by-six unit.
// ----------------------------------------------------------------------------
module lgrk4_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [lgrk4_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lgrk4_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  lgrk4_pkg::req_item_t                   req,
    input  lgrk4_pkg::dp_cmd_t                     dp_cmd,
    output lgrk4_pkg::dp_sts_t                     sts,
    output lgrk4_pkg::rsp_item_t                   rsp
);
    import lgrk4_pkg::*;

    localparam int MAG_W   = VAL_W + 1;
    localparam int PART_W  = 32;
    localparam int HI_W    = MAG_W - PART_W;
    localparam int PP_W    = 2 * PART_W;
    localparam int ACC_W   = 2 * MAG_W;
    localparam int OPND_W  = VAL_W + 2;
    localparam int SUM_W   = DIV_ITERS * DIV_BITS;
    localparam int YSUM_W  = SUM_W + 1;
    localparam int SH_RATIO = INVCAP_W;
    localparam int SH_TREND = GROWTH_W - 2;
    localparam int SH_SLOPE = FRAC_BITS;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [YSUM_W-1:0] WIDE_MAX =
        {{(YSUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [YSUM_W-1:0] WIDE_MIN =
        {{(YSUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] PROD_LIM = ACC_W'(1) << (VAL_W - 1);
    localparam logic [DIV_BITS-1:0] DIV_BY = DIV_BITS'(6);
    localparam logic [SUM_W-1:0] DIV_BIAS = SUM_W'(5);

    typedef struct packed {
        logic                    sat;
        logic signed [VAL_W-1:0] val;
    } clip_t;

    function automatic clip_t clip48(input logic signed [YSUM_W-1:0] v);
        clip_t c;
        if (v > WIDE_MAX) begin
            c.sat = 1'b1;
            c.val = VAL_MAX;
        end
        else if (v < WIDE_MIN) begin
            c.sat = 1'b1;
            c.val = VAL_MIN;
        end
        else begin
            c.sat = 1'b0;
            c.val = v[VAL_W-1:0];
        end
        return c;
    endfunction

    function automatic logic signed [YSUM_W-1:0] sx(input logic signed [VAL_W-1:0] x);
        return {{(YSUM_W-VAL_W){x[VAL_W-1]}}, x};
    endfunction

    // Registers
    logic [INIT_W-1:0]           init_reg;
    logic signed [GROWTH_W-1:0]  growth_reg;
    logic [INVCAP_W-1:0]         invcap_reg;
    logic signed [VAL_W-1:0]     y_reg,     y_next;
    logic                        sat_reg,   sat_next;
    logic [STEP_COUNT_BITS-1:0]  steps_reg, steps_next;
    logic                        pp_vld_reg;
    logic [DIV_BITS-2:0]         rem_reg,   rem_next;
    logic signed [VAL_W-1:0]     ybase_reg;
    logic signed [VAL_W-1:0]     q_reg;
    logic signed [VAL_W-1:0]     r_reg;
    logic signed [VAL_W-1:0]     t_reg;
    logic signed [VAL_W-1:0]     k_reg;
    logic signed [SUM_W-1:0]     sum_reg,   sum_next;
    logic [MAG_W-1:0]            mag_a_reg, mag_b_reg;
    logic                        neg_reg;
    logic [PP_W-1:0]             pp_reg,    pp_next;
    logic [1:0]                  pp_sh_reg;
    logic [ACC_W-1:0]            acc_reg,   acc_next;
    logic [SUM_W-1:0]            div_reg,   div_next;
    logic                        div_neg_reg;
    rsp_item_t                   rsp_reg;

    // Combinational values
    logic signed [OPND_W-1:0]    om;
    logic signed [OPND_W-1:0]    opa, opb;
    logic signed [OPND_W-1:0]    abs_a, abs_b;
    logic [PART_W-1:0]           a_part, b_part;
    logic [ACC_W-1:0]            pp_ext;
    logic [ACC_W-1:0]            qsh, qn, qneg;
    logic                        rem_nz;
    clip_t                       mres;
    logic signed [SUM_W-1:0]     k_ext;
    clip_t                       qclip;
    logic [SUM_W-1:0]            div_mag;
    logic [DIV_BITS-1:0]         digit;
    logic [DIV_BITS-1:0]         digit_sub;
    logic signed [SUM_W-1:0]     quot;
    clip_t                       yclip;

    // Select multiplier operands
    assign om = (OPND_W'(1) <<< FRAC_BITS) - {{(OPND_W-VAL_W){r_reg[VAL_W-1]}}, r_reg};

    always_comb
    begin
        case (dp_cmd.op)
            MOP_RATIO:
            begin
                opa = {{(OPND_W-VAL_W){q_reg[VAL_W-1]}}, q_reg};
                opb = {{(OPND_W-INVCAP_W){1'b0}}, invcap_reg};
            end
            MOP_TREND:
            begin
                opa = {{(OPND_W-VAL_W){q_reg[VAL_W-1]}}, q_reg};
                opb = {{(OPND_W-GROWTH_W){growth_reg[GROWTH_W-1]}}, growth_reg};
            end
            MOP_SLOPE:
            begin
                opa = {{(OPND_W-VAL_W){t_reg[VAL_W-1]}}, t_reg};
                opb = om;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        abs_a = opa[OPND_W-1] ? -opa : opa;
        abs_b = opb[OPND_W-1] ? -opb : opb;
    end

    // Form one partial product
    always_comb
    begin
        a_part = dp_cmd.pp_sel[1] ? {{(PART_W-HI_W){1'b0}}, mag_a_reg[MAG_W-1:PART_W]}
                                  : mag_a_reg[PART_W-1:0];
        b_part = dp_cmd.pp_sel[0] ? {{(PART_W-HI_W){1'b0}}, mag_b_reg[MAG_W-1:PART_W]}
                                  : mag_b_reg[PART_W-1:0];
        pp_next = a_part * b_part;
    end

    // Accumulate the previous partial product at its weight
    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_ext = {{(ACC_W-PP_W){1'b0}}, pp_reg};
            2'd1:    pp_ext = {{(ACC_W-PP_W){1'b0}}, pp_reg} << PART_W;
            default: pp_ext = {{(ACC_W-PP_W){1'b0}}, pp_reg} << (2 * PART_W);
        endcase
        acc_next = acc_reg;
        if (dp_cmd.mul_load)
            acc_next = '0;
        else if (pp_vld_reg)
            acc_next = acc_reg + pp_ext;
    end

    // Shift, round toward minus infinity and clip the product
    always_comb
    begin
        case (dp_cmd.op)
            MOP_RATIO:
            begin
                qsh    = acc_reg >> SH_RATIO;
                rem_nz = |acc_reg[SH_RATIO-1:0];
            end
            MOP_TREND:
            begin
                qsh    = acc_reg >> SH_TREND;
                rem_nz = |acc_reg[SH_TREND-1:0];
            end
            default:
            begin
                qsh    = acc_reg >> SH_SLOPE;
                rem_nz = |acc_reg[SH_SLOPE-1:0];
            end
        endcase
        qn   = qsh + ACC_W'(rem_nz);
        qneg = ACC_W'(0) - qn;
        if (neg_reg) begin
            if (qn > PROD_LIM) begin
                mres.sat = 1'b1;
                mres.val = VAL_MIN;
            end
            else begin
                mres.sat = 1'b0;
                mres.val = qneg[VAL_W-1:0];
            end
        end
        else begin
            if (qsh >= PROD_LIM) begin
                mres.sat = 1'b1;
                mres.val = VAL_MAX;
            end
            else begin
                mres.sat = 1'b0;
                mres.val = qsh[VAL_W-1:0];
            end
        end
    end

    // Weight the slope into the sum and form the next stage point
    always_comb
    begin
        k_ext = {{(SUM_W-VAL_W){k_reg[VAL_W-1]}}, k_reg};
        if (dp_cmd.stage == STAGE_K2 || dp_cmd.stage == STAGE_K3)
            sum_next = sum_reg + (k_ext <<< 1);
        else
            sum_next = sum_reg + k_ext;
        if (dp_cmd.stage == STAGE_K3)
            qclip = clip48(sx(ybase_reg) + sx(k_reg));
        else
            qclip = clip48(sx(ybase_reg) + sx(k_reg >>> 1));
    end

    // Divide by six, four quotient bits per cycle
    assign div_mag = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg + DIV_BIAS) : sum_reg;

    always_comb
    begin
        div_next  = div_reg;
        rem_next  = rem_reg;
        digit     = '0;
        digit_sub = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            digit     = {rem_next, div_next[SUM_W-1]};
            digit_sub = digit - DIV_BY;
            if (digit >= DIV_BY) begin
                div_next = {div_next[SUM_W-2:0], 1'b1};
                rem_next = digit_sub[DIV_BITS-2:0];
            end
            else begin
                div_next = {div_next[SUM_W-2:0], 1'b0};
                rem_next = digit[DIV_BITS-2:0];
            end
        end
    end

    // Apply the weighted average to the population
    always_comb
    begin
        quot  = div_neg_reg ? (SUM_W'(0) - div_reg) : div_reg;
        yclip = clip48(sx(ybase_reg) + {quot[SUM_W-1], quot});
    end

    // Next values of state kept across transactions
    always_comb
    begin
        y_next     = y_reg;
        sat_next   = sat_reg;
        steps_next = steps_reg;
        if (dp_cmd.in_load) begin
            sat_next   = 1'b0;
            steps_next = req.step_count;
            if (dp_cmd.restart)
                y_next = {1'b0, init_reg};
        end
        if (dp_cmd.step_start)
            steps_next = steps_reg - STEP_COUNT_BITS'(1);
        if (dp_cmd.mul_fin && mres.sat)
            sat_next = 1'b1;
        if (dp_cmd.acc && dp_cmd.stage != STAGE_K4 && qclip.sat)
            sat_next = 1'b1;
        if (dp_cmd.y_update) begin
            y_next = yclip.val;
            if (yclip.sat)
                sat_next = 1'b1;
        end
    end

    // Hold configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            init_reg   <= '0;
            growth_reg <= '0;
            invcap_reg <= '0;
            y_reg      <= '0;
            sat_reg    <= 1'b0;
            steps_reg  <= '0;
            pp_vld_reg <= 1'b0;
            rem_reg    <= '0;
        end
        else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_INITIAL: init_reg   <= cfg_data[INIT_W-1:0];
                    CFG_GROWTH:  growth_reg <= cfg_data[GROWTH_W-1:0];
                    CFG_INVCAP:  invcap_reg <= cfg_data[INVCAP_W-1:0];
                    default:     ;
                endcase
            end
            y_reg      <= y_next;
            sat_reg    <= sat_next;
            steps_reg  <= steps_next;
            pp_vld_reg <= dp_cmd.mul_pp;
            if (dp_cmd.div_load)
                rem_reg <= '0;
            else if (dp_cmd.div_run)
                rem_reg <= rem_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.step_start) begin
            ybase_reg <= y_reg;
            q_reg     <= y_reg;
            sum_reg   <= '0;
        end
        if (dp_cmd.mul_load) begin
            mag_a_reg <= abs_a[MAG_W-1:0];
            mag_b_reg <= abs_b[MAG_W-1:0];
            neg_reg   <= opa[OPND_W-1] ^ opb[OPND_W-1];
        end
        if (dp_cmd.mul_pp) begin
            pp_reg    <= pp_next;
            pp_sh_reg <= 2'(dp_cmd.pp_sel[1]) + 2'(dp_cmd.pp_sel[0]);
        end
        acc_reg <= acc_next;
        if (dp_cmd.mul_fin) begin
            case (dp_cmd.op)
                MOP_RATIO: r_reg <= mres.val;
                MOP_TREND: t_reg <= mres.val;
                default:   k_reg <= mres.val;
            endcase
        end
        if (dp_cmd.acc) begin
            sum_reg <= sum_next;
            if (dp_cmd.stage != STAGE_K4)
                q_reg <= qclip.val;
        end
        if (dp_cmd.div_load) begin
            div_reg     <= div_mag;
            div_neg_reg <= sum_reg[SUM_W-1];
        end
        else if (dp_cmd.div_run) begin
            div_reg <= div_next;
        end
        if (dp_cmd.out_load) begin
            rsp_reg.population <= y_reg;
            rsp_reg.saturated  <= sat_reg;
        end
    end

    assign sts.steps_zero = (steps_reg == '0);
    assign rsp            = rsp_reg;

    // Checks
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < DIV_BY)
        else $error("divider remainder out of range");

    a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.mul_fin |-> !pp_vld_reg)
        else $error("product taken before last partial product was added");

endmodule

### rtl/lgrk4_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrk4_ctrl
// Controller: sequences restart and advance transactions, the three products
// of each slope, the four RK4 stages, the divide and the result handoff.
// ----------------------------------------------------------------------------
module lgrk4_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_func,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  lgrk4_pkg::dp_sts_t   sts,
    output lgrk4_pkg::dp_cmd_t   dp_cmd
);
    import lgrk4_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_STEP   = 11'b000_0000_0010,
        ST_MLOAD  = 11'b000_0000_0100,
        ST_MPP    = 11'b000_0000_1000,
        ST_MDRAIN = 11'b000_0001_0000,
        ST_MFIN   = 11'b000_0010_0000,
        ST_ACC    = 11'b000_0100_0000,
        ST_DLOAD  = 11'b000_1000_0000,
        ST_DIV    = 11'b001_0000_0000,
        ST_UPD    = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } state_t;

    localparam logic [1:0]       PP_LAST  = 2'd3;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_ITERS - 1);

    state_t           state_reg, state_next;
    mul_op_t          op_reg,    op_next;
    logic [1:0]       stage_reg, stage_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Sequence the datapath
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        stage_next    = stage_reg;
        cnt_next      = cnt_reg;
        dp_cmd        = '0;
        dp_cmd.op     = op_reg;
        dp_cmd.stage  = stage_reg;
        dp_cmd.pp_sel = cnt_reg[1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid) begin
                    dp_cmd.in_load = 1'b1;
                    dp_cmd.restart = !req_func;
                    state_next     = req_func ? ST_STEP : ST_DONE;
                end
            end
            ST_STEP:
            begin
                if (sts.steps_zero) begin
                    state_next = ST_DONE;
                end
                else begin
                    dp_cmd.step_start = 1'b1;
                    stage_next        = STAGE_K1;
                    op_next           = MOP_RATIO;
                    state_next        = ST_MLOAD;
                end
            end
            ST_MLOAD:
            begin
                dp_cmd.mul_load = 1'b1;
                cnt_next        = '0;
                state_next      = ST_MPP;
            end
            ST_MPP:
            begin
                dp_cmd.mul_pp = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg[1:0] == PP_LAST)
                    state_next = ST_MDRAIN;
            end
            ST_MDRAIN:
            begin
                state_next = ST_MFIN;
            end
            ST_MFIN:
            begin
                dp_cmd.mul_fin = 1'b1;
                case (op_reg)
                    MOP_RATIO:
                    begin
                        op_next    = MOP_TREND;
                        state_next = ST_MLOAD;
                    end
                    MOP_TREND:
                    begin
                        op_next    = MOP_SLOPE;
                        state_next = ST_MLOAD;
                    end
                    default:
                    begin
                        state_next = ST_ACC;
                    end
                endcase
            end
            ST_ACC:
            begin
                dp_cmd.acc = 1'b1;
                if (stage_reg == STAGE_K4) begin
                    state_next = ST_DLOAD;
                end
                else begin
                    stage_next = stage_reg + 2'd1;
                    op_next    = MOP_RATIO;
                    state_next = ST_MLOAD;
                end
            end
            ST_DLOAD:
            begin
                dp_cmd.div_load = 1'b1;
                cnt_next        = '0;
                state_next      = ST_DIV;
            end
            ST_DIV:
            begin
                dp_cmd.div_run = 1'b1;
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                dp_cmd.y_update = 1'b1;
                state_next      = ST_STEP;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall) begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (dp_cmd.out_load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            op_reg        <= MOP_RATIO;
            stage_reg     <= STAGE_K1;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            stage_reg     <= stage_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ST_IDLE))
        else $error("controller idle right after accepting a transaction");

    a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MFIN) |-> ($past(state_reg) == ST_MDRAIN))
        else $error("product finished without drain cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> !(rsp_valid_reg && rsp_stall))
        else $error("result overwritten while stalled");

endmodule

### rtl/logistic_growth_rk4_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logistic_growth_rk4_integrator
// Fixed-point logistic ODE integrator using classic fourth-order Runge-Kutta.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------------
//   req     | req_valid / req_stall  | func, step_count
//   rsp     | rsp_valid / rsp_stall  | population, saturated
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A restart reloads the initial population and goes straight to the result.
// An advance runs step_count RK4 steps; each step computes 12 products on
// the shared 32x32 multiplier (four partial products each) and uses the
// divide-by-six unit and the stage and update logic.
// One transaction is in work at a time; a finished result waits in the
// output register while the next transaction is accepted and computed.
// Reset clears the population, the flag and all configuration registers.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module logistic_growth_rk4_integrator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  lgrk4_pkg::req_item_t                req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output lgrk4_pkg::rsp_item_t                rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lgrk4_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lgrk4_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lgrk4_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;
    logic    cfg_we;

    // Take configuration writes in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    lgrk4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_func  (req.func),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (dp_sts),
        .dp_cmd    (dp_cmd)
    );

    lgrk4_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .dp_cmd    (dp_cmd),
        .sts       (dp_sts),
        .rsp       (rsp)
    );

endmodule
